>>> rtl/core/txcw_pkg.sv
package txcw_pkg;

    // item modes carried on s_tuser
    localparam logic [2:0] MODE_TEXT   = 3'd0;
    localparam logic [2:0] MODE_RAW    = 3'd1;
    localparam logic [2:0] MODE_SETPOS = 3'd2;
    localparam logic [2:0] MODE_CLEAR  = 3'd3;
    localparam logic [2:0] MODE_READ   = 3'd4;

    // special character codes
    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_BLANK   = 8'h20;

    // reset value of the blank attribute register
    localparam logic [7:0] BLANK_ATTR_RST = 8'h0F;

    // field widths
    localparam int unsigned MODE_W   = 3;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned OCOL_W   = 7;
    localparam int unsigned OROW_W   = 5;
    localparam int unsigned S_DATA_W = 32;
    localparam int unsigned M_DATA_W = 32;

    // one cell: attribute in the high byte, character in the low byte
    typedef struct packed {
        logic [BYTE_W-1:0] attr;
        logic [BYTE_W-1:0] ch;
    } cell_t;

endpackage

>>> rtl/core/text_console_writer.sv
// channel    | dir | contents
// -----------+-----+--------------------------------------------------------------
// s_ (item)  | in  | tuser: mode; tdata: char_code, attr, pos_x, pos_y
// m_ (item)  | out | tdata: cursor_col, cursor_row, cell_char, cell_attr, did_scroll
// cfg_wr     | in  | blank_attr, written on an edge with cfg_wr_en high, out of reset
//
// print, newline, set cursor, read cell and unused modes go from idle to done and back.
// a clear, and a print or newline that scrolls, first run the fill state over every cell,
// one cell memory port pair moving one cell per cycle (registered read, one write).
// aresetn is synchronous, active low; it clears the cursor and control, not cells.
// the result waits in an output register; a new item is taken while it waits,
// but the next result holds its last cycle until m_tready frees the register.
module text_console_writer #(
    parameter int unsigned COLS = 80,
    parameter int unsigned ROWS = 25
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                cfg_wr_en,
    input  logic [txcw_pkg::BYTE_W-1:0]         cfg_wr_data,
    // input items
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [txcw_pkg::S_DATA_W-1:0]       s_tdata,  // char_code, attr, pos_x, pos_y
    input  logic [txcw_pkg::MODE_W-1:0]         s_tuser,  // mode
    // result items
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [txcw_pkg::M_DATA_W-1:0]       m_tdata   // cursor_col, cursor_row,
                                                           // cell_char, cell_attr,
                                                           // did_scroll, zero fill
);
    import txcw_pkg::*;

    localparam int unsigned CELLS = COLS * ROWS;
    localparam int unsigned AW    = $clog2(CELLS);
    localparam int unsigned CW    = $clog2(COLS);
    localparam int unsigned RW    = $clog2(ROWS);

    localparam logic [CW-1:0]     COL_LAST   = CW'(COLS - 1);
    localparam logic [RW-1:0]     ROW_LAST   = RW'(ROWS - 1);
    localparam logic [BYTE_W-1:0] X_MAX      = BYTE_W'(COLS - 1);
    localparam logic [BYTE_W-1:0] Y_MAX      = BYTE_W'(ROWS - 1);
    localparam logic [AW-1:0]     COLS_A     = AW'(COLS);
    localparam logic [AW-1:0]     CELL_LAST  = AW'(CELLS - 1);
    localparam logic [AW-1:0]     MOVE_END   = AW'(CELLS - COLS);
    localparam logic [AW:0]       CELLS_X    = (AW + 1)'(CELLS);
    localparam logic [AW:0]       RD_AHEAD   = (AW + 1)'(COLS + 1);

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_FILL = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // cell memory
    cell_t mem [CELLS];
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    cell_t         mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    cell_t         mem_rdata;

    // control and cursor state
    logic [1:0]        state_reg, state_next;
    logic [CW-1:0]     col_reg, col_next;
    logic [RW-1:0]     row_reg, row_next;
    logic [AW-1:0]     ptr_reg, ptr_next;
    logic              scroll_reg, scroll_next;
    logic              rd_item_reg, rd_item_next;
    logic [BYTE_W-1:0] blank_attr_reg;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    // input fields
    logic [MODE_W-1:0] in_mode;
    logic [BYTE_W-1:0] in_char, in_attr, in_x, in_y;
    logic [CW-1:0]     clamp_x;
    logic [RW-1:0]     clamp_y;
    logic              accept, put_req, nl_req;
    logic [AW-1:0]     cur_addr, pos_addr;
    logic [AW:0]       rd_ahead;
    cell_t             blank;
    cell_t             rd_cell;

    assign in_mode = s_tuser;
    assign in_char = s_tdata[7:0];
    assign in_attr = s_tdata[15:8];
    assign in_x    = s_tdata[23:16];
    assign in_y    = s_tdata[31:24];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // position clamp and cell addresses
    assign clamp_x  = (in_x > X_MAX) ? COL_LAST : CW'(in_x);
    assign clamp_y  = (in_y > Y_MAX) ? ROW_LAST : RW'(in_y);
    assign cur_addr = AW'(row_reg) * COLS_A + AW'(col_reg);
    assign pos_addr = AW'(clamp_y) * COLS_A + AW'(clamp_x);
    assign rd_ahead = {1'b0, ptr_reg} + RD_AHEAD;

    assign blank.attr = blank_attr_reg;
    assign blank.ch   = CHAR_BLANK;

    // printable and newline decode
    assign put_req = ((in_mode == MODE_TEXT) && (in_char != CHAR_NUL)
                      && (in_char != CHAR_NEWLINE))
                  || ((in_mode == MODE_RAW) && (in_char != CHAR_NUL) && !in_char[7]);
    assign nl_req  = (in_mode == MODE_TEXT) && (in_char == CHAR_NEWLINE);

    // sequencer
    always_comb begin
        state_next    = state_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        ptr_next      = ptr_reg;
        scroll_next   = scroll_reg;
        rd_item_next  = rd_item_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        mem_we        = 1'b0;
        mem_waddr     = cur_addr;
        mem_wdata     = blank;
        mem_re        = 1'b0;
        mem_raddr     = pos_addr;
        rd_cell       = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next   = ST_DONE;
                    scroll_next  = 1'b0;
                    rd_item_next = 1'b0;
                    ptr_next     = '0;
                    if (put_req || nl_req) begin
                        // print writes at the cursor, then the cursor advances
                        if (put_req) begin
                            mem_we         = 1'b1;
                            mem_wdata.attr = in_attr;
                            mem_wdata.ch   = in_char;
                        end
                        if (nl_req || (col_reg == COL_LAST)) begin
                            col_next = '0;
                            if (row_reg == ROW_LAST) begin
                                // prime the first moved cell and start the scroll
                                scroll_next = 1'b1;
                                mem_re      = 1'b1;
                                mem_raddr   = COLS_A;
                                state_next  = ST_FILL;
                            end else begin
                                row_next = row_reg + RW'(1);
                            end
                        end else begin
                            col_next = col_reg + CW'(1);
                        end
                    end else if (in_mode == MODE_SETPOS) begin
                        col_next = clamp_x;
                        row_next = clamp_y;
                    end else if (in_mode == MODE_CLEAR) begin
                        col_next   = '0;
                        row_next   = '0;
                        state_next = ST_FILL;
                    end else if (in_mode == MODE_READ) begin
                        mem_re       = 1'b1;
                        rd_item_next = 1'b1;
                    end
                end
            end
            ST_FILL: begin
                // one cell per cycle: moved row data while scrolling, else blank
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                if (scroll_reg && (ptr_reg < MOVE_END)) begin
                    mem_wdata = mem_rdata;
                end
                if (scroll_reg && (rd_ahead < CELLS_X)) begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(rd_ahead);
                end
                if (ptr_reg == CELL_LAST) begin
                    state_next = ST_DONE;
                end else begin
                    ptr_next = ptr_reg + AW'(1);
                end
            end
            ST_DONE: begin
                // hand the result over once the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    if (rd_item_reg) begin
                        rd_cell = mem_rdata;
                    end
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_DATA_W'({scroll_reg, rd_cell.attr, rd_cell.ch,
                                               OROW_W'(row_reg), OCOL_W'(col_reg)});
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            col_reg        <= '0;
            row_reg        <= '0;
            ptr_reg        <= '0;
            scroll_reg     <= 1'b0;
            rd_item_reg    <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            blank_attr_reg <= BLANK_ATTR_RST;
        end else begin
            state_reg    <= state_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            ptr_reg      <= ptr_next;
            scroll_reg   <= scroll_next;
            rd_item_reg  <= rd_item_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                blank_attr_reg <= cfg_wr_data;
            end
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    // cell memory, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_rdata <= mem[mem_raddr];
        end
    end

endmodule
